// ===== design/lcadc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcadc_pkg
// Shared codes, widths and types for the load-cell converter readout block.
// ----------------------------------------------------------------------------
package lcadc_pkg;

  localparam int SUM_BITS = 28;
  localparam int THRESH_BITS = 24;
  localparam int COUNT_BITS = 5;
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_CHECK = 2'd1;
  localparam logic [1:0] ACT_CAPTURE = 2'd2;

  // register select is paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_SAMPLES = 1'b1;

  localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = 24'd5000;
  localparam logic [COUNT_BITS-1:0] SAMPLES_RESET = 5'd10;

  typedef struct packed {
    logic start;
    logic start_capture;
    logic word_end;
  } meas_ctl_t;

endpackage

// ===== design/load_cell_adc_reader_detector.sv =====
// ----------------------------------------------------------------------------
// load_cell_adc_reader_detector
// Two-wire load-cell converter readout with baseline capture and object check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one request per pin-timing tick with
//   the action code and the sampled data pin level.
//   Output channel (out_valid/out_stall): one result per input request with
//   the clock pin level to drive, busy, done, was_capture, object_present
//   and the last finished measurement sum.
//   out_valid rises in the cycle after acceptance; one request can be accepted
//   every cycle while out_stall is low, set by the single result register.
//   While the receiver stalls, the result register holds and in_stall is
//   raised until the result is taken; a result is taken and the next
//   request accepted in the same cycle.
//   APB port: detect_threshold at 0x0, samples_per_measure at 0x4; pready
//   is always high.
//   Reset (rst, synchronous) returns to idle, clears sums and baseline and
//   loads threshold 5000 and 10 reads per measurement.
// ----------------------------------------------------------------------------
module load_cell_adc_reader_detector
  import lcadc_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int MAX_READS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           action,
  input  logic                 data_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 clock_level,
  output logic                 busy_res,
  output logic                 done_res,
  output logic                 was_capture,
  output logic                 object_present,
  output logic [SUM_BITS-1:0]  measure_sum,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  logic [THRESH_BITS-1:0] detect_threshold;
  logic [COUNT_BITS-1:0]  samples_per_measure;

  logic                   step;
  meas_ctl_t              ctl;
  logic [SAMPLE_BITS-1:0] word;
  logic                   last_read;
  logic                   clk_lvl, busy, done, was_cap, obj;
  logic [SUM_BITS-1:0]    sum;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_threshold <= THRESHOLD_RESET;
      samples_per_measure <= SAMPLES_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_THRESHOLD: detect_threshold <= pwdata[THRESH_BITS-1:0];
        REG_SAMPLES:   samples_per_measure <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_THRESHOLD: prdata = DATA_BITS'(detect_threshold);
      REG_SAMPLES:   prdata = DATA_BITS'(samples_per_measure);
      default:       prdata = '0;
    endcase
  end

  assign in_stall = out_valid && out_stall;
  assign step = in_valid && !in_stall;

  lcadc_serial #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_serial (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .action     (action),
    .data_level (data_level),
    .last_read  (last_read),
    .ctl        (ctl),
    .word       (word),
    .clock_level(clk_lvl),
    .busy       (busy)
  );

  lcadc_accum #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_READS  (MAX_READS)
  ) u_accum (
    .clk                (clk),
    .rst                (rst),
    .step               (step),
    .ctl                (ctl),
    .word               (word),
    .detect_threshold   (detect_threshold),
    .samples_per_measure(samples_per_measure),
    .last_read          (last_read),
    .done               (done),
    .was_capture        (was_cap),
    .object_present     (obj),
    .measure_sum        (sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      clock_level <= clk_lvl;
      busy_res <= busy;
      done_res <= done;
      was_capture <= was_cap;
      object_present <= obj;
      measure_sum <= sum;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done result reports busy");

  a_obj_on_check: assert property (@(posedge clk) disable iff (rst)
    out_valid && object_present |-> done_res && !was_capture)
    else $error("object flag outside a finished check");

  a_clk_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && clock_level |-> busy_res)
    else $error("serial clock high while idle");
`endif

endmodule

// ===== design/lcadc_serial.sv =====
// ----------------------------------------------------------------------------
// lcadc_serial
// Serial clock sequencer: waits for data low, gives SAMPLE_BITS+1 clock
// pulses and shifts in one converter word, MSB first.
// ----------------------------------------------------------------------------
module lcadc_serial
  import lcadc_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [1:0]             action,
  input  logic                   data_level,
  input  logic                   last_read,
  output meas_ctl_t              ctl,
  output logic [SAMPLE_BITS-1:0] word,
  output logic                   clock_level,
  output logic                   busy
);

  localparam int BW = $clog2(SAMPLE_BITS + 2);
  localparam logic [BW-1:0] LAST_BIT = BW'(SAMPLE_BITS + 1);
  localparam logic [BW-1:0] WORD_BIT = BW'(SAMPLE_BITS);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_WAIT = 4'b0010,
    PH_HIGH = 4'b0100,
    PH_LOW  = 4'b1000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [BW-1:0]          bit_count, bit_count_next;
  logic [SAMPLE_BITS-1:0] shift_word, shift_word_next;

  always_comb begin
    phase_next = phase;
    bit_count_next = bit_count;
    shift_word_next = shift_word;
    ctl = '0;
    clock_level = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (action == ACT_CHECK || action == ACT_CAPTURE) begin
          ctl.start = 1'b1;
          ctl.start_capture = (action == ACT_CAPTURE);
          bit_count_next = '0;
          shift_word_next = '0;
          phase_next = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (!data_level) begin
          bit_count_next = '0;
          shift_word_next = '0;
          phase_next = PH_HIGH;
        end
      end
      PH_HIGH: begin
        if (bit_count != '0 && bit_count <= WORD_BIT) begin
          shift_word_next = {shift_word[SAMPLE_BITS-2:0], data_level};
        end
        bit_count_next = bit_count + 1'b1;
        clock_level = 1'b1;
        phase_next = PH_LOW;
      end
      PH_LOW: begin
        if (bit_count < LAST_BIT) begin
          phase_next = PH_HIGH;
        end else begin
          ctl.word_end = 1'b1;
          phase_next = last_read ? PH_IDLE : PH_WAIT;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  assign word = shift_word;
  assign busy = (phase_next != PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      bit_count <= '0;
      shift_word <= '0;
    end else if (step) begin
      phase <= phase_next;
      bit_count <= bit_count_next;
      shift_word <= shift_word_next;
    end
  end

endmodule

// ===== design/lcadc_accum.sv =====
// ----------------------------------------------------------------------------
// lcadc_accum
// Sums offset-binary words per measurement, holds the baseline and makes
// the object decision against threshold times read count.
// ----------------------------------------------------------------------------
module lcadc_accum
  import lcadc_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int MAX_READS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  meas_ctl_t              ctl,
  input  logic [SAMPLE_BITS-1:0] word,
  input  logic [THRESH_BITS-1:0] detect_threshold,
  input  logic [COUNT_BITS-1:0]  samples_per_measure,
  output logic                   last_read,
  output logic                   done,
  output logic                   was_capture,
  output logic                   object_present,
  output logic [SUM_BITS-1:0]    measure_sum
);

  localparam int RCW = $clog2(MAX_READS + 1);
  localparam int CW = (RCW > COUNT_BITS) ? RCW : COUNT_BITS;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_READS);
  localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam int PW = THRESH_BITS + CW;

  logic [RCW-1:0]      read_count;
  logic [SUM_BITS-1:0] running_sum, baseline_sum, last_sum;
  logic                capture_mode;

  logic [CW-1:0]       samples_ext, wanted, read_inc;
  logic [SUM_BITS-1:0] sum_add, diff;
  logic [PW-1:0]       limit;

  always_comb begin
    samples_ext = CW'(samples_per_measure);
    if (samples_ext == '0) begin
      wanted = CW'(1);
    end else if (samples_ext > MAX_C) begin
      wanted = MAX_C;
    end else begin
      wanted = samples_ext;
    end
  end

  assign read_inc = CW'(read_count) + CW'(1);
  assign last_read = (read_inc >= wanted);
  assign sum_add = running_sum + SUM_BITS'(word ^ SIGN_FLIP);
  assign diff = (sum_add >= baseline_sum) ? (sum_add - baseline_sum)
                                          : (baseline_sum - sum_add);
  assign limit = PW'(detect_threshold) * PW'(read_inc);

  assign done = ctl.word_end && last_read;
  assign was_capture = done && capture_mode;
  assign object_present = done && !capture_mode && (PW'(diff) > limit);
  assign measure_sum = done ? sum_add : last_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_count <= '0;
      running_sum <= '0;
      baseline_sum <= '0;
      last_sum <= '0;
      capture_mode <= 1'b0;
    end else if (step) begin
      if (ctl.start) begin
        capture_mode <= ctl.start_capture;
        read_count <= '0;
        running_sum <= '0;
      end else if (ctl.word_end) begin
        running_sum <= sum_add;
        read_count <= read_inc[RCW-1:0];
        if (last_read) begin
          last_sum <= sum_add;
          if (capture_mode) begin
            baseline_sum <= sum_add;
          end
        end
      end
    end
  end

endmodule
